@@ src/clu_pkg.sv @@
// Package for the character LCD interface sequencer: codes, control word
// layout, row base table and the microcode program. No dependencies.
package clu_pkg;

    localparam int PC_W = 7;

    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_INSTR   = 3'd1;
    localparam logic [2:0] MODE_DATA    = 3'd2;
    localparam logic [2:0] MODE_CURSOR  = 3'd3;
    localparam logic [2:0] MODE_BLIGHT  = 3'd4;

    localparam logic [1:0] BUS_GPIO8    = 2'd0;
    localparam logic [1:0] BUS_I2C      = 2'd2;

    localparam logic [5:0] DLY_POWERUP_MS = 6'd50;
    localparam logic [7:0] CURSOR_CMD     = 8'h80;

    localparam logic [PC_W-1:0] UA_INIT   = 7'd0;
    localparam logic [PC_W-1:0] UA_B30A   = 7'd1;
    localparam logic [PC_W-1:0] UA_B30B   = 7'd7;
    localparam logic [PC_W-1:0] UA_B30C   = 7'd13;
    localparam logic [PC_W-1:0] UA_BRANCH = 7'd19;
    localparam logic [PC_W-1:0] UA_B20    = 7'd20;
    localparam logic [PC_W-1:0] UA_B28    = 7'd26;
    localparam logic [PC_W-1:0] UA_B38    = 7'd32;
    localparam logic [PC_W-1:0] UA_B08    = 7'd38;
    localparam logic [PC_W-1:0] UA_B01    = 7'd44;
    localparam logic [PC_W-1:0] UA_B06    = 7'd50;
    localparam logic [PC_W-1:0] UA_B0C    = 7'd56;
    localparam logic [PC_W-1:0] UA_INSTR  = 7'd62;
    localparam logic [PC_W-1:0] UA_DATA   = 7'd68;
    localparam logic [PC_W-1:0] UA_CURSOR = 7'd74;
    localparam logic [PC_W-1:0] UA_BLIGHT = 7'd80;

    typedef enum logic [1:0] {PIN_KEEP, PIN_SETUP, PIN_EN_HI, PIN_EN_LO} pin_op_t;
    typedef enum logic [1:0] {SRC_CONST, SRC_INPUT, SRC_CURSOR} src_t;
    typedef enum logic [2:0] {DLY_ZERO, DLY_ONE, DLY_INIT, DLY_FINAL, DLY_HALF} dly_t;
    typedef enum logic [1:0] {JMP_NONE, JMP_HALF, JMP_EIGHT, JMP_ALWAYS} jmp_t;
    typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

    typedef struct packed {
        logic            emit;
        pin_op_t         pin_op;
        logic            nib_lo;
        logic            rs;
        src_t            src;
        logic [7:0]      konst;
        logic [2:0]      extra;
        dly_t            dly;
        logic            set_bl;
        logic            clr_ready;
        logic            set_ready;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
        logic            done;
    } uword_t;

    typedef struct packed {
        logic       fire;
        logic       emit;
        pin_op_t    pin_op;
        logic [3:0] nib;
        logic       rs;
        logic       set_bl;
        logic       load_low;
        logic [3:0] low_val;
        logic [5:0] delay;
        logic       last;
    } dp_ctl_t;

    function automatic logic [7:0] row_base(logic [1:0] row);
        logic [7:0] b;
        case (row)
            2'd0:    b = 8'd0;
            2'd1:    b = 8'd64;
            2'd2:    b = 8'd20;
            2'd3:    b = 8'd84;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // One byte transfer: high nibble pulse, then the low nibble pulse that the
    // half-byte jump skips when nibble mode is not active.
    function automatic uword_t byte_word(logic [2:0] ofs, src_t src, logic [7:0] konst,
                                         logic rs, logic [2:0] extra,
                                         logic [PC_W-1:0] nxt, logic done,
                                         logic set_rdy, logic jump_out);
        uword_t w;
        w        = '0;
        w.emit   = 1'b1;
        w.src    = src;
        w.konst  = konst;
        w.rs     = rs;
        w.extra  = extra;
        w.target = nxt;
        case (ofs)
            3'd0: begin
                w.pin_op = PIN_SETUP;
                w.dly    = DLY_ZERO;
            end
            3'd1: begin
                w.pin_op = PIN_EN_HI;
                w.dly    = DLY_ONE;
            end
            3'd2: begin
                w.pin_op    = PIN_EN_LO;
                w.dly       = DLY_HALF;
                w.jmp       = JMP_HALF;
                w.done      = done;
                w.set_ready = set_rdy;
            end
            3'd3: begin
                w.pin_op = PIN_SETUP;
                w.nib_lo = 1'b1;
                w.dly    = DLY_ZERO;
            end
            3'd4: begin
                w.pin_op = PIN_EN_HI;
                w.dly    = DLY_ONE;
            end
            3'd5: begin
                w.pin_op = PIN_EN_LO;
                w.dly    = DLY_FINAL;
                w.done   = done;
                w.jmp    = jump_out ? JMP_ALWAYS : JMP_NONE;
            end
            default: begin
                w      = '0;
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic uword_t ucode_word(logic [PC_W-1:0] pc);
        uword_t w;
        w = '0;
        case (pc) inside
            UA_INIT: begin
                w.emit      = 1'b1;
                w.pin_op    = PIN_KEEP;
                w.dly       = DLY_INIT;
                w.set_bl    = 1'b1;
                w.clr_ready = 1'b1;
            end
            [UA_B30A:UA_B30A+7'd5]:
                w = byte_word(3'(pc - UA_B30A), SRC_CONST, 8'h30, 1'b0, 3'd5,
                              UA_B30B, 1'b0, 1'b0, 1'b0);
            [UA_B30B:UA_B30B+7'd5]:
                w = byte_word(3'(pc - UA_B30B), SRC_CONST, 8'h30, 1'b0, 3'd1,
                              UA_B30C, 1'b0, 1'b0, 1'b0);
            [UA_B30C:UA_B30C+7'd5]:
                w = byte_word(3'(pc - UA_B30C), SRC_CONST, 8'h30, 1'b0, 3'd1,
                              UA_BRANCH, 1'b0, 1'b0, 1'b0);
            UA_BRANCH: begin
                w.jmp    = JMP_EIGHT;
                w.target = UA_B38;
            end
            [UA_B20:UA_B20+7'd5]:
                w = byte_word(3'(pc - UA_B20), SRC_CONST, 8'h20, 1'b0, 3'd1,
                              UA_B28, 1'b0, 1'b1, 1'b0);
            [UA_B28:UA_B28+7'd5]:
                w = byte_word(3'(pc - UA_B28), SRC_CONST, 8'h28, 1'b0, 3'd1,
                              UA_B08, 1'b0, 1'b0, 1'b1);
            [UA_B38:UA_B38+7'd5]:
                w = byte_word(3'(pc - UA_B38), SRC_CONST, 8'h38, 1'b0, 3'd1,
                              UA_B08, 1'b0, 1'b0, 1'b0);
            [UA_B08:UA_B08+7'd5]:
                w = byte_word(3'(pc - UA_B08), SRC_CONST, 8'h08, 1'b0, 3'd1,
                              UA_B01, 1'b0, 1'b0, 1'b0);
            [UA_B01:UA_B01+7'd5]:
                w = byte_word(3'(pc - UA_B01), SRC_CONST, 8'h01, 1'b0, 3'd1,
                              UA_B06, 1'b0, 1'b0, 1'b0);
            [UA_B06:UA_B06+7'd5]:
                w = byte_word(3'(pc - UA_B06), SRC_CONST, 8'h06, 1'b0, 3'd1,
                              UA_B0C, 1'b0, 1'b0, 1'b0);
            [UA_B0C:UA_B0C+7'd5]:
                w = byte_word(3'(pc - UA_B0C), SRC_CONST, 8'h0C, 1'b0, 3'd1,
                              UA_INIT, 1'b1, 1'b0, 1'b0);
            [UA_INSTR:UA_INSTR+7'd5]:
                w = byte_word(3'(pc - UA_INSTR), SRC_INPUT, 8'h00, 1'b0, 3'd0,
                              UA_INIT, 1'b1, 1'b0, 1'b0);
            [UA_DATA:UA_DATA+7'd5]:
                w = byte_word(3'(pc - UA_DATA), SRC_INPUT, 8'h00, 1'b1, 3'd0,
                              UA_INIT, 1'b1, 1'b0, 1'b0);
            [UA_CURSOR:UA_CURSOR+7'd5]:
                w = byte_word(3'(pc - UA_CURSOR), SRC_CURSOR, 8'h00, 1'b0, 3'd1,
                              UA_INIT, 1'b1, 1'b0, 1'b0);
            UA_BLIGHT: begin
                w.emit   = 1'b1;
                w.pin_op = PIN_KEEP;
                w.dly    = DLY_ZERO;
                w.set_bl = 1'b1;
                w.done   = 1'b1;
            end
            default: w.done = 1'b1;
        endcase
        return w;
    endfunction

endpackage

@@ src/char_lcd_interface_sequencer_core.sv @@
// Top level of the character LCD interface sequencer: wiring register,
// sequencer and datapath. Depends on clu_pkg, clu_seq, clu_dp.
//
// Commands enter on the s_ channel (mode, byte_value, column, row); each
// accepted beat becomes a run of pin snapshots on the m_ channel, each with
// the wait in ms to hold it, m_last marking the final beat of the command.
// Init gives 43 beats (25 in eight-bit GPIO wiring), a byte 3 or 6, a cursor
// move 3 or 6, backlight refresh 1; unused mode codes give none.
// A command is taken only when the sequencer is idle. The first beat is
// registered from the first microcode step after acceptance; then one beat
// per cycle from a microcode step counter while the receiver keeps up, and
// init adds a non-emitting step for the wiring branch.
// The output register decouples the sides: a stalled receiver holds the
// sequencer on its next emitting step, and the next command can be accepted
// while the final beat still waits.
// Wiring is set by cfg_wr_en/cfg_wr_data (0 eight-bit GPIO, 1 four-bit GPIO,
// 2 or 3 I2C expander); the user must write it only while idle (unenforced).
// Reset selects I2C wiring, clears pin and low data latches and nibble mode.
module char_lcd_interface_sequencer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_byte_value,
    input  logic [5:0] s_column,
    input  logic [1:0] s_row,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_bus_byte,
    output logic [3:0] m_low_data,
    output logic [5:0] m_delay_ms,
    output logic       m_last
);

    logic [1:0]       bus_kind_reg;
    logic             out_free;
    clu_pkg::dp_ctl_t ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_kind_reg <= clu_pkg::BUS_I2C;
        end else if (cfg_wr_en) begin
            bus_kind_reg <= cfg_wr_data;
        end
    end

    clu_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_byte_value (s_byte_value),
        .s_column     (s_column),
        .s_row        (s_row),
        .bus_kind     (bus_kind_reg),
        .out_free     (out_free),
        .ctl          (ctl)
    );

    clu_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .bus_kind   (bus_kind_reg),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_bus_byte (m_bus_byte),
        .m_low_data (m_low_data),
        .m_delay_ms (m_delay_ms),
        .m_last     (m_last)
    );

    // An emitting step must never overwrite a beat still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fire && ctl.emit |-> !m_valid || m_ready)
        else $error("beat register overwritten");

    // Enable-high snapshots hold exactly one millisecond.
    a_en_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bus_byte[2] |-> m_delay_ms == 6'd1)
        else $error("enable pulse width wrong");

    // A command never ends with enable still high.
    a_last_en_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_bus_byte[2])
        else $error("command ended with enable high");

    // Unused mode codes leave the block idle.
    a_unused_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode > clu_pkg::MODE_BLIGHT)
        |=> s_ready)
        else $error("unused mode started a run");

endmodule

@@ src/clu_seq.sv @@
// Microcode sequencer: command capture, step counter, control store lookup,
// conditional jumps and nibble-mode flag. Depends on clu_pkg.
module clu_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_mode,
    input  logic [7:0]            s_byte_value,
    input  logic [5:0]            s_column,
    input  logic [1:0]            s_row,
    input  logic [1:0]            bus_kind,
    input  logic                  out_free,
    output clu_pkg::dp_ctl_t      ctl
);

    clu_pkg::seq_state_t         state_reg, state_next;
    logic [clu_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic                        ready_reg, ready_next;
    logic [7:0]                  byte_reg;
    logic [5:0]                  column_reg;
    logic [1:0]                  row_reg;
    clu_pkg::uword_t             w;
    logic                        eight_bit;
    logic                        nib_active;
    logic                        skip;
    logic                        finish;
    logic                        go;
    logic [7:0]                  byte_cur;
    logic [7:0]                  cursor_byte;
    logic [5:0]                  final_dly;

    assign w           = clu_pkg::ucode_word(pc_reg);
    assign eight_bit   = (bus_kind == clu_pkg::BUS_GPIO8);
    assign nib_active  = !eight_bit && ready_reg;
    assign cursor_byte = clu_pkg::CURSOR_CMD | (clu_pkg::row_base(row_reg) + {2'b00, column_reg});
    assign skip        = (w.jmp == clu_pkg::JMP_HALF) && !nib_active;
    assign finish      = w.done && ((w.jmp != clu_pkg::JMP_HALF) || skip);
    assign go          = (state_reg == clu_pkg::SEQ_RUN) && (!w.emit || out_free);
    assign final_dly   = 6'd1 + {3'b000, w.extra};
    assign s_ready     = (state_reg == clu_pkg::SEQ_IDLE);

    always_comb begin
        case (w.src)
            clu_pkg::SRC_INPUT:  byte_cur = byte_reg;
            clu_pkg::SRC_CURSOR: byte_cur = cursor_byte;
            default:             byte_cur = w.konst;
        endcase
    end

    always_comb begin
        ctl.fire     = go;
        ctl.emit     = w.emit;
        ctl.pin_op   = w.pin_op;
        ctl.nib      = w.nib_lo ? byte_cur[3:0] : byte_cur[7:4];
        ctl.rs       = w.rs;
        ctl.set_bl   = w.set_bl;
        ctl.load_low = (w.pin_op == clu_pkg::PIN_SETUP) && !w.nib_lo && eight_bit;
        ctl.low_val  = byte_cur[3:0];
        ctl.last     = finish;
        case (w.dly)
            clu_pkg::DLY_ONE:   ctl.delay = 6'd1;
            clu_pkg::DLY_INIT:  ctl.delay = clu_pkg::DLY_POWERUP_MS;
            clu_pkg::DLY_FINAL: ctl.delay = final_dly;
            clu_pkg::DLY_HALF:  ctl.delay = nib_active ? 6'd1 : final_dly;
            default:            ctl.delay = 6'd0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ready_next = ready_reg;
        case (state_reg)
            clu_pkg::SEQ_IDLE: begin
                if (s_valid) begin
                    state_next = clu_pkg::SEQ_RUN;
                    case (s_mode)
                        clu_pkg::MODE_INIT:   pc_next = clu_pkg::UA_INIT;
                        clu_pkg::MODE_INSTR:  pc_next = clu_pkg::UA_INSTR;
                        clu_pkg::MODE_DATA:   pc_next = clu_pkg::UA_DATA;
                        clu_pkg::MODE_CURSOR: pc_next = clu_pkg::UA_CURSOR;
                        clu_pkg::MODE_BLIGHT: pc_next = clu_pkg::UA_BLIGHT;
                        default:              state_next = clu_pkg::SEQ_IDLE;
                    endcase
                end
            end
            clu_pkg::SEQ_RUN: begin
                if (go) begin
                    if (w.clr_ready) begin
                        ready_next = 1'b0;
                    end else if (w.set_ready) begin
                        ready_next = 1'b1;
                    end
                    if (finish) begin
                        state_next = clu_pkg::SEQ_IDLE;
                    end else if (skip || (w.jmp == clu_pkg::JMP_ALWAYS)
                                 || ((w.jmp == clu_pkg::JMP_EIGHT) && eight_bit)) begin
                        pc_next = w.target;
                    end else begin
                        pc_next = pc_reg + 7'd1;
                    end
                end
            end
            default: state_next = clu_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clu_pkg::SEQ_IDLE;
            pc_reg    <= clu_pkg::UA_INIT;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg   <= s_byte_value;
            column_reg <= s_column;
            row_reg    <= s_row;
        end
    end

endmodule

@@ src/clu_dp.sv @@
// Datapath: pin latch, low data latch and the output beat register driven
// by the sequencer's control word. Depends on clu_pkg.
module clu_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  clu_pkg::dp_ctl_t  ctl,
    input  logic [1:0]        bus_kind,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_bus_byte,
    output logic [3:0]        m_low_data,
    output logic [5:0]        m_delay_ms,
    output logic              m_last
);

    logic [7:0] pin_reg, pin_next, pin_op_val;
    logic [3:0] low_reg, low_next;
    logic       valid_reg;
    logic [7:0] bus_byte_reg;
    logic [3:0] low_data_reg;
    logic [5:0] delay_reg;
    logic       last_reg;
    logic       eight_bit;
    logic       i2c;

    assign eight_bit = (bus_kind == clu_pkg::BUS_GPIO8);
    assign i2c       = bus_kind[1];
    assign out_free  = !valid_reg || m_ready;

    always_comb begin
        case (ctl.pin_op)
            clu_pkg::PIN_SETUP: pin_op_val = {ctl.nib, pin_reg[3], 2'b00, ctl.rs};
            clu_pkg::PIN_EN_HI: pin_op_val = pin_reg | 8'h04;
            clu_pkg::PIN_EN_LO: pin_op_val = pin_reg & 8'hFB;
            default:            pin_op_val = pin_reg;
        endcase
        pin_next = (ctl.set_bl && i2c) ? (pin_op_val | 8'h08) : pin_op_val;
        low_next = ctl.load_low ? ctl.low_val : low_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_reg   <= 8'd0;
            low_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            if (ctl.fire) begin
                pin_reg <= pin_next;
                low_reg <= low_next;
            end
            if (ctl.fire && ctl.emit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fire && ctl.emit) begin
            bus_byte_reg <= pin_next;
            low_data_reg <= eight_bit ? low_next : 4'd0;
            delay_reg    <= ctl.delay;
            last_reg     <= ctl.last;
        end
    end

    assign m_valid    = valid_reg;
    assign m_bus_byte = bus_byte_reg;
    assign m_low_data = low_data_reg;
    assign m_delay_ms = delay_reg;
    assign m_last     = last_reg;

endmodule
